// ----- sv/cse_pkg.sv -----
// Shared types and constants for the CAN signal extractor.
`default_nettype none
package cse_pkg;

  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] REG_LOW_BIT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HIGH_BIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BITS       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEL      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SIGNED     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROLLING    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CHECK_ON   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_BAD_LIMIT  = 3'd7;

  typedef struct packed {
    logic [8:0] low_bit;
    logic [8:0] high_bit;
    logic [6:0] bits;
    logic       intel;
    logic       signed_sig;
    logic       rolling;
    logic       check_on;
    logic [7:0] bad_limit;
  } cfg_t;

  // Signal width clamped to 0..64.
  function automatic logic [6:0] eff_bits(input logic [6:0] bits);
    logic [6:0] r;
    r = (bits > 7'd64) ? 7'd64 : bits;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cse_byte_take.sv -----
// Bits one payload byte contributes to the signal, from its place in the byte walk.
`default_nettype none
module cse_byte_take (
  input  wire cse_pkg::cfg_t cfg,
  input  wire logic [5:0]    pos,
  input  wire logic [7:0]    data,
  output logic [63:0]        contrib
);

  logic [5:0]         s_byte;
  logic [5:0]         l_byte;
  logic [2:0]         lo7;
  logic [2:0]         hi7;
  logic [6:0]         eff;
  logic [3:0]         piece_s;
  logic [2:0]         lo_p;
  logic [2:0]         hi_p;
  logic [3:0]         sz_p;
  logic               dir_ok;
  logic [5:0]         span;
  logic               between;
  logic signed [10:0] used;
  logic signed [10:0] rem;
  logic               reach;
  logic [6:0]         rem_u;
  logic [7:0]         bits_sel;
  logic [8:0]         mask9;
  logic [5:0]         up_sh;
  logic [2:0]         dn_sh;

  always_comb begin
    s_byte  = cfg.high_bit[8:3];
    l_byte  = cfg.low_bit[8:3];
    lo7     = cfg.low_bit[2:0];
    hi7     = cfg.high_bit[2:0];
    eff     = cse_pkg::eff_bits(cfg.bits);

    piece_s = (l_byte == s_byte && lo7 > hi7) ? 4'd0
            : 4'({1'b0, hi7} - ((l_byte == s_byte) ? {1'b0, lo7} : 4'd0) + 4'd1);

    lo_p    = (l_byte == pos) ? lo7 : 3'd0;
    hi_p    = (s_byte == pos) ? hi7 : 3'd7;
    sz_p    = (lo_p > hi_p) ? 4'd0 : 4'({1'b0, hi_p} - {1'b0, lo_p} + 4'd1);

    if (cfg.intel) begin
      dir_ok  = (pos <= s_byte);
      span    = s_byte - pos;
      between = (l_byte > pos) && (l_byte < s_byte);
    end else begin
      dir_ok  = (pos >= s_byte);
      span    = pos - s_byte;
      between = (l_byte > s_byte) && (l_byte < pos);
    end

    if (span == 6'd0) begin
      used = 11'sd0;
    end else begin
      used = $signed(11'(piece_s)) + $signed(11'({span - 6'd1, 3'b000}))
           - (between ? $signed(11'(lo7)) : 11'sd0);
    end
    rem   = $signed(11'(eff)) - used;
    reach = (eff != 7'd0) && dir_ok && (rem > 11'sd0) && (sz_p != 4'd0);
    rem_u = rem[6:0];

    mask9    = 9'((9'd1 << sz_p) - 9'd1);
    bits_sel = (data >> lo_p) & mask9[7:0];
    up_sh    = 6'(rem_u - 7'(sz_p));
    dn_sh    = 3'(7'(sz_p) - rem_u);

    if (!reach) begin
      contrib = 64'd0;
    end else if (rem_u >= 7'(sz_p)) begin
      contrib = {56'd0, bits_sel} << up_sh;
    end else begin
      contrib = {56'd0, bits_sel >> dn_sh};
    end
  end

endmodule
`default_nettype wire

// ----- sv/can_signal_extractor.sv -----
// Top level of the CAN signal extractor: byte intake, frame collection and counter check.
// One payload byte is taken per clock, except that a frame's last byte waits while the
// previous result is still held. Bytes pass an input register, then a collect stage that
// merges each byte's bits into the signal, then a check stage that does sign extension
// and the rolling counter check into the result register. Frames longer than MAX_FRAME_BYTES
// produce no result and leave the counter state as is. Configuration is written through
// cfg_write/cfg_index/cfg_data only while idle by the user; the block itself does not enforce this.
`default_nettype none
module can_signal_extractor #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [cse_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [cse_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   payload_byte,
  input  wire logic                         frame_end,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [63:0]                signal_value,
  output logic                              frame_accepted,
  output logic                              sequence_error,
  output logic [7:0]                        bad_count
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);

  cse_pkg::cfg_t cfg;

  logic            in_full;
  logic [7:0]      in_byte;
  logic            in_end;

  logic [PosW-1:0] pos;
  logic [63:0]     acc;
  logic            overlong;

  logic            fin_valid;
  logic [63:0]     fin_value;
  logic [PosW-1:0] fin_pos;

  logic [7:0]      prev;
  logic [7:0]      tally;

  logic            out_free;
  logic            fin_move;
  logic            fin_free;
  logic            in_go;
  logic            over_now;
  logic [63:0]     contrib;
  logic [63:0]     acc_next;
  logic [PosW-1:0] pos_next;

  logic [6:0]      size;
  logic [63:0]     low_mask;
  logic [63:0]     v0;
  logic [63:0]     v;
  logic            ext;
  logic            check;
  logic            mismatch;
  logic [7:0]      tally_up;
  logic [7:0]      tally_next;
  logic            accept_next;

  cse_byte_take u_take (
    .cfg     (cfg),
    .pos     (6'(pos)),
    .data    (in_byte),
    .contrib (contrib)
  );

  always_comb begin
    out_free = !out_valid || out_ready;
    fin_move = fin_valid && out_free;
    fin_free = !fin_valid || fin_move;
    in_go    = in_full && (!in_end || fin_free);
    in_ready = !in_full || in_go;

    over_now = overlong || (pos >= PosW'(MAX_FRAME_BYTES));
    acc_next = over_now ? acc : (acc | contrib);
    pos_next = over_now ? pos : PosW'(pos + PosW'(1));
  end

  always_comb begin
    size     = cse_pkg::eff_bits(cfg.bits);
    low_mask = (size >= 7'd64) ? {64{1'b1}} : ((64'd1 << size) - 64'd1);
    v0       = fin_value;
    if (cfg.intel && (10'(fin_pos) <= 10'(cfg.high_bit[8:3]))) begin
      v0 = 64'd0;
    end
    if (size == 7'd0) begin
      v0 = 64'd0;
    end
    ext = cfg.signed_sig && (size >= 7'd1) && (size < 7'd64) && v0[6'(size - 7'd1)];
    v   = ext ? (v0 | ~low_mask) : v0;

    check       = cfg.check_on && cfg.rolling;
    mismatch    = ((64'(prev) + 64'd1) & low_mask) != v;
    tally_up    = (tally == 8'hFF) ? tally : tally + 8'd1;
    tally_next  = tally;
    accept_next = 1'b1;
    if (check) begin
      if (mismatch) begin
        tally_next  = tally_up;
        accept_next = !(tally_up >= cfg.bad_limit);
      end else if (tally != 8'd0) begin
        tally_next = tally - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_bit    <= 9'd0;
      cfg.high_bit   <= 9'd7;
      cfg.bits       <= 7'd8;
      cfg.intel      <= 1'b1;
      cfg.signed_sig <= 1'b0;
      cfg.rolling    <= 1'b0;
      cfg.check_on   <= 1'b1;
      cfg.bad_limit  <= 8'd5;
    end else if (cfg_write) begin
      case (cfg_index)
        cse_pkg::REG_LOW_BIT:   cfg.low_bit    <= cfg_data[8:0];
        cse_pkg::REG_HIGH_BIT:  cfg.high_bit   <= cfg_data[8:0];
        cse_pkg::REG_BITS:      cfg.bits       <= cfg_data[6:0];
        cse_pkg::REG_INTEL:     cfg.intel      <= cfg_data[0];
        cse_pkg::REG_SIGNED:    cfg.signed_sig <= cfg_data[0];
        cse_pkg::REG_ROLLING:   cfg.rolling    <= cfg_data[0];
        cse_pkg::REG_CHECK_ON:  cfg.check_on   <= cfg_data[0];
        cse_pkg::REG_BAD_LIMIT: cfg.bad_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_byte <= payload_byte;
      in_end  <= frame_end;
    end
  end

  // collect stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      acc       <= 64'd0;
      overlong  <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (in_go) begin
        if (in_end) begin
          pos      <= '0;
          acc      <= 64'd0;
          overlong <= 1'b0;
          if (!over_now) begin
            fin_valid <= 1'b1;
            fin_value <= acc_next;
            fin_pos   <= pos_next;
          end
        end else begin
          pos      <= pos_next;
          acc      <= acc_next;
          overlong <= over_now;
        end
      end
    end
  end

  // check stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev      <= 8'd0;
      tally     <= 8'd0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fin_move) begin
        out_valid      <= 1'b1;
        signal_value   <= $signed(v);
        frame_accepted <= accept_next;
        sequence_error <= check && mismatch;
        bad_count      <= tally_next;
        tally          <= tally_next;
        if (check) begin
          prev <= v[7:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_can_signal_extractor.sv -----
// Testbench for can_signal_extractor: directed and random frames checked by a scoreboard.
`timescale 1ns / 1ps
module tb_can_signal_extractor;

  localparam int FRAME_MAX      = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 200;

  typedef struct packed {
    logic [63:0] value;
    logic        accepted;
    logic        seq_err;
    logic [7:0]  tally;
  } decoded_t;

  class signal_scoreboard;
    cse_pkg::cfg_t regs;
    logic [6:0]  byte_idx;
    logic [63:0] gathered;
    logic        too_long;
    logic [7:0]  last_count;
    logic [7:0]  tally;
    decoded_t    decoded_due[$];
    int          mismatches;

    function new();
      regs.low_bit    = 9'd0;
      regs.high_bit   = 9'd7;
      regs.bits       = 7'd8;
      regs.intel      = 1'b1;
      regs.signed_sig = 1'b0;
      regs.rolling    = 1'b0;
      regs.check_on   = 1'b1;
      regs.bad_limit  = 8'd5;
      byte_idx   = '0;
      gathered   = '0;
      too_long   = 1'b0;
      last_count = '0;
      tally      = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [cse_pkg::CfgIdxW-1:0] idx,
                           logic [cse_pkg::CfgDataW-1:0] data);
      case (idx)
        cse_pkg::REG_LOW_BIT:   regs.low_bit = data;
        cse_pkg::REG_HIGH_BIT:  regs.high_bit = data;
        cse_pkg::REG_BITS:      regs.bits = data[6:0];
        cse_pkg::REG_INTEL:     regs.intel = data[0];
        cse_pkg::REG_SIGNED:    regs.signed_sig = data[0];
        cse_pkg::REG_ROLLING:   regs.rolling = data[0];
        cse_pkg::REG_CHECK_ON:  regs.check_on = data[0];
        cse_pkg::REG_BAD_LIMIT: regs.bad_limit = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return decoded_due.size();
    endfunction

    function int signal_width();
      return (regs.bits > 7'd64) ? 64 : int'(regs.bits);
    endfunction

    // bits of byte j that belong to the signal: width returned, offset in byte via off
    function int piece(int j, output int off);
      int lo;
      int hi;
      lo = (int'(regs.low_bit >> 3) == j) ? int'(regs.low_bit) : j * 8;
      hi = (int'(regs.high_bit >> 3) == j) ? int'(regs.high_bit) : j * 8 + 7;
      off = lo - j * 8;
      return (hi - lo + 1 > 0) ? hi - lo + 1 : 0;
    endfunction

    // bits still open when the byte walk arrives at byte p
    function bit walk_left(int p, output int left);
      int s;
      int j;
      int off;
      s = int'(regs.high_bit >> 3);
      left = signal_width();
      if (left <= 0) return 1'b0;
      if (regs.intel) begin
        if (p > s) return 1'b0;
        for (j = s; j > p; j--) begin
          left -= piece(j, off);
          if (left <= 0) return 1'b0;
        end
      end else begin
        if (p < s) return 1'b0;
        for (j = s; j < p; j++) begin
          left -= piece(j, off);
          if (left <= 0) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void merge_byte(int p, logic [7:0] b);
      int left;
      int off;
      int sz;
      logic [63:0] d;
      if (!walk_left(p, left)) return;
      sz = piece(p, off);
      if (sz == 0) return;
      d = ({56'd0, b} >> off) & ((64'd1 << sz) - 64'd1);
      if (left >= sz) gathered |= d << (left - sz);
      else gathered |= d >> (sz - left);
    endfunction

    function void take_payload_byte(logic [7:0] b, logic last);
      int sz;
      logic [63:0] v;
      logic [63:0] mask;
      logic [7:0] old;
      decoded_t r;
      if (byte_idx >= FRAME_MAX) too_long = 1'b1;
      else begin
        merge_byte(int'(byte_idx), b);
        byte_idx++;
      end
      if (!last) return;
      if (too_long) begin
        byte_idx = '0;
        gathered = '0;
        too_long = 1'b0;
        return;
      end
      sz = signal_width();
      v = gathered;
      if (regs.intel && byte_idx <= (regs.high_bit >> 3)) v = '0;
      if (sz == 0) v = '0;
      if (regs.signed_sig && sz >= 1 && sz < 64 && v[sz-1]) v |= ~((64'd1 << sz) - 64'd1);
      r.value = v;
      r.accepted = 1'b1;
      r.seq_err = 1'b0;
      if (regs.check_on && regs.rolling) begin
        old = last_count;
        mask = (sz >= 64) ? '1 : ((64'd1 << sz) - 64'd1);
        last_count = v[7:0];
        if ((({56'd0, old} + 64'd1) & mask) != v) begin
          r.seq_err = 1'b1;
          if (tally < 8'd255) tally++;
          if (tally >= regs.bad_limit) r.accepted = 1'b0;
        end else if (tally > 0) begin
          tally--;
        end
      end
      r.tally = tally;
      decoded_due = {decoded_due, r};
      byte_idx = '0;
      gathered = '0;
      too_long = 1'b0;
    endfunction

    function void check_decoded(logic [63:0] value, logic ok, logic seq, logic [7:0] cnt);
      decoded_t want;
      if (decoded_due.size() == 0) begin
        $display("%0t: result with none pending: value %h accepted %b seq %b count %0d",
                 $time, value, ok, seq, cnt);
        mismatches++;
        return;
      end
      want = decoded_due.pop_front();
      if (value !== want.value) begin
        $display("%0t: signal_value expected %h actual %h", $time, want.value, value);
        mismatches++;
      end
      if (ok !== want.accepted) begin
        $display("%0t: frame_accepted expected %b actual %b", $time, want.accepted, ok);
        mismatches++;
      end
      if (seq !== want.seq_err) begin
        $display("%0t: sequence_error expected %b actual %b", $time, want.seq_err, seq);
        mismatches++;
      end
      if (cnt !== want.tally) begin
        $display("%0t: bad_count expected %0d actual %0d", $time, want.tally, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [cse_pkg::CfgIdxW-1:0] cfg_index;
  logic [cse_pkg::CfgDataW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] payload_byte;
  logic frame_end;
  logic out_valid;
  logic out_ready;
  logic signed [63:0] signal_value;
  logic frame_accepted;
  logic sequence_error;
  logic [7:0] bad_count;

  signal_scoreboard sb = new();

  logic [7:0] frame_bytes [0:71];
  int   items_sent;
  bit   steady;
  bit   squeeze;
  int   sig_lo;
  int   sig_hi;
  int   sig_n;
  int   sig_intel;
  int   sig_need;
  int   quiet;

  can_signal_extractor #(.MAX_FRAME_BYTES(FRAME_MAX)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .payload_byte(payload_byte),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .signal_value(signal_value),
    .frame_accepted(frame_accepted),
    .sequence_error(sequence_error),
    .bad_count(bad_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze) begin
        out_ready = 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        squeeze = 1'b0;
      end
      out_ready = steady || ($urandom_range(99) >= 21);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_decoded(signal_value, frame_accepted, sequence_error, bad_count);
    end
  end

  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    payload_byte = b;
    frame_end = last;
    do @(posedge clk); while (!in_ready);
    sb.take_payload_byte(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int len);
    int i;
    for (i = 0; i < len; i++) send_byte(frame_bytes[i], i == len - 1);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [cse_pkg::CfgIdxW-1:0] idx, input int val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val[cse_pkg::CfgDataW-1:0];
    @(posedge clk);
    sb.load_reg(idx, val[cse_pkg::CfgDataW-1:0]);
    @(negedge clk);
  endtask

  task automatic configure(input int lo, hi, n, intel, sgn, roll, chk, lim);
    settle();
    write_reg(cse_pkg::REG_LOW_BIT, lo);
    write_reg(cse_pkg::REG_HIGH_BIT, hi);
    write_reg(cse_pkg::REG_BITS, n);
    write_reg(cse_pkg::REG_INTEL, intel);
    write_reg(cse_pkg::REG_SIGNED, sgn);
    write_reg(cse_pkg::REG_ROLLING, roll);
    write_reg(cse_pkg::REG_CHECK_ON, chk);
    write_reg(cse_pkg::REG_BAD_LIMIT, lim);
    cfg_write = 1'b0;
  endtask

  // well-formed signal layout; Motorola bits run down a byte then into the next
  task automatic choose_signal(input int n, input int intel, input bit wide);
    int k;
    int p;
    sig_n = n;
    sig_intel = intel;
    if (intel) begin
      sig_lo = $urandom_range(wide ? 512 - n : 64 - n, 0);
      sig_hi = sig_lo + n - 1;
      sig_need = sig_hi / 8 + 1;
    end else begin
      sig_hi = 8 * $urandom_range(wide ? 54 : 7, 0) + $urandom_range(7, 0);
      p = sig_hi;
      for (k = 1; k < n; k++) p = (p % 8 == 0) ? p + 15 : p - 1;
      sig_lo = p;
      sig_need = p / 8 + 1;
    end
  endtask

  task automatic place_value(input logic [63:0] v);
    int k;
    int p;
    p = sig_hi;
    for (k = 0; k < sig_n; k++) begin
      if (sig_intel) begin
        frame_bytes[(sig_lo + k) >> 3][(sig_lo + k) & 7] = v[k];
      end else begin
        frame_bytes[p >> 3][p & 7] = v[sig_n - 1 - k];
        p = (p % 8 == 0) ? p + 15 : p - 1;
      end
    end
  endtask

  task automatic fill_random();
    int i;
    for (i = 0; i < 72; i++) frame_bytes[i] = $urandom_range(255);
  endtask

  function automatic int pick_len(input int need);
    int r;
    int base;
    r = $urandom_range(99);
    if (r < 2) return 65 + $urandom_range(3);
    if (r < 10) return $urandom_range(need, 1);
    if (r < 60) base = $urandom_range(8, 1);
    else begin
      case ($urandom_range(6))
        0: base = 12;
        1: base = 16;
        2: base = 20;
        3: base = 24;
        4: base = 32;
        5: base = 48;
        default: base = 64;
      endcase
    end
    return (base < need) ? need : base;
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(6))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 5;
      4: return 255;
      default: return $urandom_range(255, 1);
    endcase
  endfunction

  task automatic random_phase();
    int kind;
    int n;
    int r;
    int f;
    int roll;
    logic [63:0] v;
    steady = (items_sent > 120 && items_sent < 230);
    kind = $urandom_range(9);
    if (kind < 5) begin
      r = $urandom_range(99);
      n = (r < 60) ? $urandom_range(16, 1) : (r < 85) ? $urandom_range(63, 17) : 64;
      choose_signal(n, $urandom_range(1), $urandom_range(99) < 20);
      roll = $urandom_range(1);
      configure(sig_lo, sig_hi, n, sig_intel, $urandom_range(1), roll,
                roll ? 0 : $urandom_range(1), pick_limit());
      for (f = $urandom_range(12, 6); f > 0; f--) begin
        fill_random();
        place_value({$urandom, $urandom});
        send_frame(pick_len(sig_need));
      end
    end else if (kind < 8) begin
      n = $urandom_range(8, 1);
      choose_signal(n, $urandom_range(1), 1'b0);
      configure(sig_lo, sig_hi, n, sig_intel, ($urandom_range(9) == 0), 1, 1, pick_limit());
      for (f = $urandom_range(16, 8); f > 0; f--) begin
        fill_random();
        if ($urandom_range(99) < 85) v = {56'd0, sb.last_count} + 64'd1;
        else v = {$urandom, $urandom};
        place_value(v);
        send_frame(pick_len(sig_need));
      end
    end else begin
      configure($urandom_range(511), $urandom_range(511), $urandom_range(511),
                $urandom_range(511), $urandom_range(511), $urandom_range(511),
                $urandom_range(511), $urandom_range(511));
      for (f = $urandom_range(8, 4); f > 0; f--) begin
        fill_random();
        send_frame(pick_len(8));
      end
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    payload_byte = '0;
    frame_end = 1'b0;
    items_sent = 0;
    steady = 1'b0;
    squeeze = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset layout: byte 0 as unsigned 8 bits
    frame_bytes[0] = 8'h00;
    send_frame(1);
    frame_bytes[0] = 8'hFF;
    send_frame(1);
    frame_bytes[0] = 8'h5A;
    frame_bytes[1] = 8'hC3;
    send_frame(2);

    // Motorola 12-bit signed, then a short frame with the tail missing
    configure(12, 7, 12, 0, 1, 0, 1, 5);
    frame_bytes[0] = 8'h80;
    frame_bytes[1] = 8'h00;
    send_frame(2);
    frame_bytes[0] = 8'h7F;
    frame_bytes[1] = 8'hF0;
    send_frame(2);
    frame_bytes[0] = 8'h12;
    send_frame(1);

    // full 64-bit signed: no extension
    configure(0, 63, 64, 1, 1, 0, 1, 5);
    for (i = 0; i < 8; i++) frame_bytes[i] = $urandom_range(255);
    frame_bytes[7] = 8'hC5;
    send_frame(8);

    // Intel start byte beyond the frame, then zero width
    configure(40, 47, 8, 1, 1, 0, 1, 5);
    frame_bytes[0] = 8'hAA;
    send_frame(1);
    configure(0, 7, 0, 1, 1, 1, 1, 5);
    frame_bytes[0] = 8'hFF;
    send_frame(1);

    // low above high within a byte
    configure(5, 2, 8, 1, 0, 0, 1, 5);
    frame_bytes[0] = 8'hFF;
    frame_bytes[1] = 8'hFF;
    send_frame(2);

    // counter in sequence, then a skip that fails at limit 1
    configure(0, 3, 4, 1, 0, 1, 1, 1);
    frame_bytes[0] = 8'h01;
    send_frame(1);
    frame_bytes[0] = 8'h03;
    send_frame(1);

    while (items_sent < 300) random_phase();

    // stuck counter drives the tally to saturation; receiver holds off meanwhile
    configure(0, 7, 8, 1, 0, 1, 1, 255);
    steady = 1'b1;
    squeeze = 1'b1;
    frame_bytes[0] = 8'h00;
    repeat (270) send_frame(1);
    steady = 1'b0;

    while (items_sent < 680) random_phase();

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d decoded results never arrived", $time, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
